// File: design/nvd_pkg.sv
`default_nettype none

package nvd_pkg;

  localparam int SAMPLE_W = 8;
  localparam int LL_W     = 11;
  localparam int AW_W     = 10;
  localparam int PHASE_W  = 5;
  localparam int GAP_W    = 3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [LL_W-1:0] LINE_LENGTH_RST  = 11'd800;
  localparam logic [AW_W-1:0] ACTIVE_WIDTH_RST = 10'd792;

  localparam logic [PHASE_W-1:0] COL_PERIOD      = 5'd24;
  localparam logic [PHASE_W-1:0] ROW_PERIOD_LUMA = 5'd24;
  localparam logic [PHASE_W-1:0] ROW_PERIOD_CHR  = 5'd12;

  // kept phases; bits at 24 and above stay clear
  localparam logic [31:0] LUMA_MASK   = 32'h000C_C333;
  localparam logic [31:0] CHROMA_MASK = 32'h0000_0295;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_LENGTH  = 1'b0,
    CFG_ACTIVE_WIDTH = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [LL_W-1:0] line_length;
    logic [AW_W-1:0] active_width;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] pixel;
    logic                out_plane;
    logic                line_end;
  } res_t;

  // distance from a kept column phase to the next kept column
  function automatic logic [GAP_W-1:0] next_gap(logic [PHASE_W-1:0] phase);
    logic [GAP_W-1:0] gap;
    case (phase)
      5'd0, 5'd4, 5'd8, 5'd14, 5'd18: gap = 3'd1;
      5'd1, 5'd5, 5'd15:              gap = 3'd3;
      5'd9, 5'd19:                    gap = 3'd5;
      default:                        gap = 3'd1;
    endcase
    return gap;
  endfunction

endpackage

`default_nettype wire

// File: design/nvd_if.sv
`default_nettype none

interface nvd_in_if;
  logic                         valid;
  logic                         ready;
  logic [nvd_pkg::SAMPLE_W-1:0] sample;
  logic                         plane;
  logic                         plane_start;

  modport source (output valid, output sample, output plane, output plane_start,
                  input ready);
  modport sink   (input valid, input sample, input plane, input plane_start,
                  output ready);
endinterface

interface nvd_out_if;
  logic                         valid;
  logic                         ready;
  logic [nvd_pkg::SAMPLE_W-1:0] pixel;
  logic                         out_plane;
  logic                         line_end;

  modport source (output valid, output pixel, output out_plane, output line_end,
                  input ready);
  modport sink   (input valid, input pixel, input out_plane, input line_end,
                  output ready);
endinterface

interface nvd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [nvd_pkg::CFG_IDX_W-1:0]  index;
  logic [nvd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/nvd_cfg_regs.sv
`default_nettype none

module nvd_cfg_regs (
  input  wire           clk_i,
  input  wire           rst_ni,
  nvd_cfg_if.sink       cfg_i,
  output nvd_pkg::cfg_t cfg_o
);
  import nvd_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_LINE_LENGTH:  cfg_d.line_length  = cfg_i.data[LL_W-1:0];
        CFG_ACTIVE_WIDTH: cfg_d.active_width = cfg_i.data[AW_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_length  <= LINE_LENGTH_RST;
      cfg_q.active_width <= ACTIVE_WIDTH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: design/nvd_decim.sv
`default_nettype none

module nvd_decim #(
  parameter int MAX_LINE_LENGTH = 1024
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire nvd_pkg::cfg_t cfg_i,
  nvd_in_if.sink             in_i,
  output nvd_pkg::res_t      res_o,
  output logic               res_valid_o,
  input  wire                res_ready_i
);
  import nvd_pkg::*;

  localparam int CW   = $clog2(MAX_LINE_LENGTH);
  localparam int LLW  = $clog2(MAX_LINE_LENGTH + 1);
  localparam int CMPW = ((LLW > LL_W) ? LLW : LL_W) + 1;

  // input register
  logic                s1_valid_q;
  logic [SAMPLE_W-1:0] s1_sample_q;
  logic                s1_plane_q;
  logic                s1_start_q;

  // position counters
  logic [CW-1:0]      col_q, col_d;
  logic [PHASE_W-1:0] cmod_q, cmod_d;
  logic [PHASE_W-1:0] row_q, row_d;

  logic [CW-1:0]      col;
  logic [PHASE_W-1:0] cmod;
  logic [PHASE_W-1:0] row;
  logic [CMPW-1:0]    ll_raw, ll_eff, aw_ext, limit, col_x;
  logic [PHASE_W-1:0] period;
  logic [31:0]        rmask;
  logic               keep;
  logic               wrap;
  logic               s1_go;
  logic [PHASE_W:0]   row_inc;

  always_comb begin
    ll_raw = CMPW'(cfg_i.line_length);
    if (ll_raw == '0) begin
      ll_eff = CMPW'(1);
    end else if (ll_raw > CMPW'(MAX_LINE_LENGTH)) begin
      ll_eff = CMPW'(MAX_LINE_LENGTH);
    end else begin
      ll_eff = ll_raw;
    end
    aw_ext = CMPW'(cfg_i.active_width);
    limit  = (aw_ext < ll_eff) ? aw_ext : ll_eff;
  end

  always_comb begin
    col    = s1_start_q ? '0 : col_q;
    cmod   = s1_start_q ? '0 : cmod_q;
    row    = s1_start_q ? '0 : row_q;
    col_x  = CMPW'(col);
    period = s1_plane_q ? ROW_PERIOD_CHR : ROW_PERIOD_LUMA;
    rmask  = s1_plane_q ? CHROMA_MASK : LUMA_MASK;
    keep   = (col_x < limit) && LUMA_MASK[cmod] && rmask[row];
    wrap   = (col_x + CMPW'(1)) >= ll_eff;

    res_o.pixel     = s1_sample_q;
    res_o.out_plane = s1_plane_q;
    res_o.line_end  = (col_x + CMPW'(next_gap(cmod))) >= limit;
    res_valid_o     = s1_valid_q && keep;

    row_inc = {1'b0, row} + (PHASE_W+1)'(1);
    if (wrap) begin
      col_d  = '0;
      cmod_d = '0;
      row_d  = (row_inc >= {1'b0, period}) ? '0 : row_inc[PHASE_W-1:0];
    end else begin
      col_d  = col + CW'(1);
      cmod_d = (cmod == COL_PERIOD - 5'd1) ? '0 : cmod + 5'd1;
      row_d  = row;
    end
  end

  assign s1_go      = s1_valid_q && (!keep || res_ready_i);
  assign in_i.ready = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      col_q      <= '0;
      cmod_q     <= '0;
      row_q      <= '0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_go) begin
        col_q  <= col_d;
        cmod_q <= cmod_d;
        row_q  <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_sample_q <= in_i.sample;
      s1_plane_q  <= in_i.plane;
      s1_start_q  <= in_i.plane_start;
    end
  end

`ifndef ASSERT_OFF
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMPW'(col_q) < CMPW'(MAX_LINE_LENGTH))
    else $error("column counter out of range");

  a_cmod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmod_q < COL_PERIOD)
    else $error("column phase out of range");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q < ROW_PERIOD_LUMA)
    else $error("row phase out of range");

  a_wrap_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && wrap |=> col_q == '0 && cmod_q == '0)
    else $error("line wrap did not clear column");
`endif

endmodule

`default_nettype wire

// File: design/nvd_out_reg.sv
`default_nettype none

module nvd_out_reg (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire nvd_pkg::res_t res_i,
  input  wire                res_valid_i,
  output logic               res_ready_o,
  nvd_out_if.source          out_o
);
  import nvd_pkg::*;

  logic out_valid_q;
  res_t out_q;

  assign res_ready_o = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready_o) begin
      out_valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      out_q <= res_i;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.pixel     = out_q.pixel;
  assign out_o.out_plane = out_q.out_plane;
  assign out_o.line_end  = out_q.line_end;

`ifndef ASSERT_OFF
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_o |=> out_valid_q)
    else $error("result register lost an item");

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(out_q))
    else $error("result register changed while stalled");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_o.ready && !res_valid_i |=> !out_valid_q)
    else $error("result register repeated an item");
`endif

endmodule

`default_nettype wire

// File: design/nv12_decimate_5_of_12.sv
// NV12 5/12 nearest-neighbor decimator.
// in_i carries one frame byte per item in raster order: luma plane, then
// interleaved CbCr, with plane_start set on the first byte of each plane.
// Columns under active_width whose phase mod 24 is 0,1,4,5,8,9,14,15,18,19
// are kept; rows follow the same pattern for luma and 0,2,4,7,9 mod 12 for
// chroma. out_o carries each kept byte with line_end on the last kept byte
// of a line. cfg_i writes line_length (index 0) and active_width (index 1);
// write only while no items are in flight.
// An item accepted on in_i passes the input register, then the result
// register, before it shows on out_o. Throughput: one item per cycle as
// long as no kept byte is held by an out_o stall, set by the column/row
// counter update.
// Reset: counters clear, line_length = 800, active_width = 792, both
// channels empty. When out_o stalls, dropped bytes keep flowing; a kept
// byte waits in the input register and in_i.ready drops only then.
`default_nettype none

module nv12_decimate_5_of_12 #(
  parameter int MAX_LINE_LENGTH = 1024
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  nvd_cfg_if.sink   cfg_i,
  nvd_in_if.sink    in_i,
  nvd_out_if.source out_o
);
  import nvd_pkg::*;

  cfg_t cfg;
  res_t res;
  logic res_valid;
  logic res_ready;

  nvd_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  nvd_decim #(
    .MAX_LINE_LENGTH (MAX_LINE_LENGTH)
  ) u_decim (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_i        (in_i),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready)
  );

  nvd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
